@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/tdma_pkg.sv @@
package tdma_pkg;

    localparam int MAX_STATES   = 16;
    localparam int STATE_W      = $clog2(MAX_STATES);
    localparam int COUNT_W      = $clog2(MAX_STATES + 1);
    localparam int OUTPUT_W     = 8;
    localparam int LABEL_W      = 8;
    localparam int LBL_DEPTH    = MAX_STATES * MAX_STATES;
    localparam int LBL_ADDR_W   = 2 * STATE_W;
    localparam int NUM_STATES_W = 5;
    localparam int FINAL_MASK_W = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [2:0] {
        KIND_LOAD_TRANS = 3'd0,
        KIND_LOAD_OUT   = 3'd1,
        KIND_START      = 3'd2,
        KIND_SYMBOL     = 3'd3,
        KIND_END        = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_MOVED     = 2'd0,
        ST_ACCEPTED  = 2'd1,
        ST_NO_TRANS  = 2'd2,
        ST_NOT_FINAL = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_STATES   = 2'd0,
        REG_INITIAL      = 2'd1,
        REG_FINAL_MASK   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         from_state;
        logic [3:0]         to_state;
        logic [LABEL_W-1:0] symbol;
        logic [7:0]         state_value;
    } in_item_t;

    typedef struct packed {
        logic [OUTPUT_W-1:0] moore_output;
        logic [3:0]          next_state;
        logic                is_end;
        logic [1:0]          status;
    } out_item_t;

endpackage

@@ hw/rtl/tdma_ram.sv @@
module tdma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/table_driven_moore_automaton_unit.sv @@
// Load and start items, and a symbol accepted while the word is dead, leave the unit idle.
// Symbol: labels of the current row are read from the label RAM one per cycle, lowest
// state first, until the first match or the end of the row (limit states) ends the scan.
// End item: result goes out via S_EMIT. One item in flight; results wait in an output reg.
// Reset (aresetn low, synchronous) clears all label valid bits at once, state 0, not dead,
// num_states 16, initial_state 0, final_mask 0. The state output RAM is not cleared.
module table_driven_moore_automaton_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [tdma_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdma_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tdma_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tdma_pkg::out_item_t                m_data
);

    import tdma_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} fsm_t;

    fsm_t                    state_reg;
    logic [NUM_STATES_W-1:0] num_states_reg;
    logic [STATE_W-1:0]      initial_reg;
    logic [FINAL_MASK_W-1:0] final_mask_reg;
    logic [STATE_W-1:0]      cur_reg;
    logic                    dead_reg;
    logic [LBL_DEPTH-1:0]    lbl_valid_reg;
    logic [LABEL_W-1:0]      sym_reg;
    logic [COUNT_W-1:0]      idx_reg;
    logic                    chk_vld_reg;
    logic [STATE_W-1:0]      chk_idx_reg;
    logic                    lbl_hit_vld_reg;
    logic [STATE_W-1:0]      res_next_reg;
    logic [1:0]              res_status_reg;
    logic                    res_end_reg;
    logic                    res_zero_reg;
    logic                    m_valid_reg;
    out_item_t               m_data_reg;

    logic                    acc;
    logic                    lbl_we;
    logic [LBL_ADDR_W-1:0]   lbl_waddr;
    logic [LBL_ADDR_W-1:0]   lbl_raddr;
    logic [LABEL_W-1:0]      lbl_rdata;
    logic                    out_we;
    logic                    out_re;
    logic [OUTPUT_W-1:0]     out_rdata;
    logic [COUNT_W-1:0]      limit;
    logic                    issue;
    logic                    found;
    logic                    slot_free;

    always_comb begin
        s_ready   = (state_reg == S_IDLE);
        acc       = s_valid && s_ready;
        lbl_we    = acc && (s_data.kind == KIND_LOAD_TRANS);
        lbl_waddr = {s_data.from_state[STATE_W-1:0], s_data.to_state[STATE_W-1:0]};
        out_we    = acc && (s_data.kind == KIND_LOAD_OUT);
        out_re    = acc && ((s_data.kind == KIND_SYMBOL) || (s_data.kind == KIND_END));
        limit     = (COUNT_W'(num_states_reg) > COUNT_W'(MAX_STATES))
                    ? COUNT_W'(MAX_STATES) : COUNT_W'(num_states_reg);
        // label 0 means no transition, so symbol 0 never matches
        found     = chk_vld_reg && lbl_hit_vld_reg && (lbl_rdata == sym_reg)
                    && (sym_reg != '0);
        issue     = (state_reg == S_SCAN) && !found && (idx_reg < limit);
        lbl_raddr = {cur_reg, idx_reg[STATE_W-1:0]};
        slot_free = !m_valid_reg || m_ready;
    end

    tdma_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (LBL_DEPTH)
    ) u_label_ram (
        .aclk  (aclk),
        .we    (lbl_we),
        .waddr (lbl_waddr),
        .wdata (s_data.symbol),
        .re    (issue),
        .raddr (lbl_raddr),
        .rdata (lbl_rdata)
    );

    tdma_ram #(
        .WIDTH (OUTPUT_W),
        .DEPTH (MAX_STATES)
    ) u_output_ram (
        .aclk  (aclk),
        .we    (out_we),
        .waddr (s_data.from_state[STATE_W-1:0]),
        .wdata (s_data.state_value[OUTPUT_W-1:0]),
        .re    (out_re),
        .raddr (cur_reg),
        .rdata (out_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            num_states_reg <= NUM_STATES_W'(MAX_STATES);
            initial_reg    <= '0;
            final_mask_reg <= '0;
            cur_reg        <= '0;
            dead_reg       <= 1'b0;
            lbl_valid_reg  <= '0;
            chk_vld_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_NUM_STATES: num_states_reg <= cfg_wdata[NUM_STATES_W-1:0];
                    REG_INITIAL:    initial_reg    <= cfg_wdata[STATE_W-1:0];
                    REG_FINAL_MASK: final_mask_reg <= cfg_wdata[FINAL_MASK_W-1:0];
                    default: ;
                endcase
            end

            // a new result loaded in S_EMIT takes over the slot
            if (m_valid_reg && m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            if (lbl_we) begin
                lbl_valid_reg[lbl_waddr] <= 1'b1;
            end

            // label read pipeline: issue now, compare next cycle
            chk_vld_reg <= issue;
            if (issue) begin
                chk_idx_reg     <= idx_reg[STATE_W-1:0];
                idx_reg         <= idx_reg + COUNT_W'(1);
                lbl_hit_vld_reg <= lbl_valid_reg[lbl_raddr];
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (acc) begin
                        case (s_data.kind)
                            KIND_START: begin
                                cur_reg  <= initial_reg;
                                dead_reg <= 1'b0;
                            end
                            KIND_SYMBOL: begin
                                if (!dead_reg) begin
                                    sym_reg   <= s_data.symbol;
                                    idx_reg   <= '0;
                                    state_reg <= S_SCAN;
                                end
                            end
                            KIND_END: begin
                                res_next_reg <= cur_reg;
                                res_end_reg  <= 1'b1;
                                res_zero_reg <= dead_reg;
                                if (dead_reg) begin
                                    res_status_reg <= ST_NO_TRANS;
                                end else if (final_mask_reg[cur_reg]) begin
                                    res_status_reg <= ST_ACCEPTED;
                                end else begin
                                    res_status_reg <= ST_NOT_FINAL;
                                end
                                state_reg <= S_EMIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (found) begin
                        cur_reg        <= chk_idx_reg;
                        res_next_reg   <= chk_idx_reg;
                        res_status_reg <= ST_MOVED;
                        res_end_reg    <= 1'b0;
                        res_zero_reg   <= 1'b0;
                        state_reg      <= S_EMIT;
                    end else if (!chk_vld_reg && (idx_reg >= limit)) begin
                        dead_reg       <= 1'b1;
                        res_next_reg   <= cur_reg;
                        res_status_reg <= ST_NO_TRANS;
                        res_end_reg    <= 1'b0;
                        res_zero_reg   <= 1'b0;
                        state_reg      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.moore_output <= res_zero_reg ? '0 : out_rdata;
                        m_data_reg.next_state   <= 4'(res_next_reg);
                        m_data_reg.is_end       <= res_end_reg;
                        m_data_reg.status       <= res_status_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hw/rtl/tdma_checker.sv @@
`include "assert_macros.svh"

module tdma_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            cfg_we,
    input logic [tdma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [tdma_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                            s_valid,
    input logic                            s_ready,
    input tdma_pkg::in_item_t              s_data,
    input logic                            m_valid,
    input logic                            m_ready,
    input tdma_pkg::out_item_t             m_data
);

    import tdma_pkg::*;

    logic cfg_seen;
    assign cfg_seen = cfg_we && (cfg_index == cfg_index) && (cfg_wdata == cfg_wdata);

    `ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    `ASSERT_IMPLIES(a_step_status, m_valid && !m_data.is_end,
        (m_data.status == ST_MOVED) || (m_data.status == ST_NO_TRANS))
    `ASSERT_IMPLIES(a_dead_end_zero,
        m_valid && m_data.is_end && (m_data.status == ST_NO_TRANS),
        m_data.moore_output == '0)
    `ASSERT_NEXT(a_end_busy, s_valid && s_ready && (s_data.kind == KIND_END), !s_ready)
    `ASSERT_NEXT(a_load_ready,
        s_valid && s_ready && !cfg_seen && ((s_data.kind == KIND_LOAD_TRANS) ||
        (s_data.kind == KIND_LOAD_OUT) || (s_data.kind == KIND_START)), s_ready)

endmodule

bind table_driven_moore_automaton_unit tdma_checker u_tdma_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

@@ test/moore_run_checker.sv @@
module moore_run_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tdma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tdma_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  tdma_pkg::in_item_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  tdma_pkg::out_item_t             m_data,
    output int                              fail_count,
    output int                              pending,
    output int                              checked
);
    import tdma_pkg::*;

    logic [LABEL_W-1:0]      labels [MAX_STATES][MAX_STATES];
    logic [OUTPUT_W-1:0]     outputs_tbl [MAX_STATES];
    logic [STATE_W-1:0]      cur_state;
    bit                      dead;
    logic [NUM_STATES_W-1:0] cfg_num;
    logic [STATE_W-1:0]      cfg_init;
    logic [FINAL_MASK_W-1:0] cfg_final;
    out_item_t               awaited_reports [$];

    initial begin
        fail_count = 0;
        pending = 0;
        checked = 0;
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Advances the automaton by one item; returns 1 when the item yields a report.
    function automatic bit step_automaton(input in_item_t it, output out_item_t rep);
        int lim;
        bit hit;
        logic [STATE_W-1:0] row;
        rep = '0;
        step_automaton = 1'b0;
        case (it.kind)
            KIND_LOAD_TRANS: labels[it.from_state][it.to_state] = it.symbol;
            KIND_LOAD_OUT:   outputs_tbl[it.from_state] = it.state_value;
            KIND_START: begin
                cur_state = cfg_init;
                dead = 1'b0;
            end
            KIND_SYMBOL: begin
                if (!dead) begin
                    lim = (cfg_num > MAX_STATES) ? MAX_STATES : int'(cfg_num);
                    row = cur_state;
                    hit = 1'b0;
                    rep.moore_output = outputs_tbl[cur_state];
                    // lowest-numbered destination wins; label zero never matches
                    for (int i = 0; i < lim && !hit; i++) begin
                        if (it.symbol != '0 && labels[row][i] == it.symbol) begin
                            hit = 1'b1;
                            cur_state = STATE_W'(i);
                        end
                    end
                    if (hit) begin
                        rep.status = ST_MOVED;
                    end else begin
                        dead = 1'b1;
                        rep.status = ST_NO_TRANS;
                    end
                    rep.next_state = cur_state;
                    step_automaton = 1'b1;
                end
            end
            KIND_END: begin
                rep.is_end = 1'b1;
                rep.next_state = cur_state;
                if (dead) begin
                    rep.moore_output = '0;
                    rep.status = ST_NO_TRANS;
                end else begin
                    rep.moore_output = outputs_tbl[cur_state];
                    rep.status = cfg_final[cur_state] ? ST_ACCEPTED : ST_NOT_FINAL;
                end
                step_automaton = 1'b1;
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t want;
        out_item_t rep;
        if (!aresetn) begin
            for (int f = 0; f < MAX_STATES; f++) begin
                outputs_tbl[f] = '0;
                for (int t = 0; t < MAX_STATES; t++)
                    labels[f][t] = '0;
            end
            cur_state = '0;
            dead = 1'b0;
            cfg_num = NUM_STATES_W'(MAX_STATES);
            cfg_init = '0;
            cfg_final = '0;
            awaited_reports.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_reports.size() == 0) begin
                    report($sformatf("result %h with nothing expected", m_data));
                end else begin
                    want = awaited_reports.pop_front();
                    checked++;
                    if (m_data.moore_output !== want.moore_output)
                        report($sformatf("moore_output got %h want %h",
                                         m_data.moore_output, want.moore_output));
                    if (m_data.next_state !== want.next_state)
                        report($sformatf("next_state got %0d want %0d",
                                         m_data.next_state, want.next_state));
                    if (m_data.is_end !== want.is_end)
                        report($sformatf("is_end got %b want %b", m_data.is_end, want.is_end));
                    if (m_data.status !== want.status)
                        report($sformatf("status got %0d want %0d", m_data.status, want.status));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_NUM_STATES: cfg_num = cfg_wdata[NUM_STATES_W-1:0];
                    REG_INITIAL:    cfg_init = cfg_wdata[STATE_W-1:0];
                    REG_FINAL_MASK: cfg_final = cfg_wdata[FINAL_MASK_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (step_automaton(s_data, rep))
                    awaited_reports = {awaited_reports, rep};
            end
        end
        pending = awaited_reports.size();
    end

endmodule

@@ test/tb_table_driven_moore_automaton_unit.sv @@
module tb_table_driven_moore_automaton_unit;
    import tdma_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;
    localparam logic [2:0]           KIND_SPARE_LO = 3'd5;
    localparam logic [2:0]           KIND_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 24;
    localparam int ITEM_TARGET   = 1200;
    localparam int DRAIN_LIMIT   = 5000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;

    int fail_count;
    int pending;
    int checked;

    // what the sender believes the automaton holds, used to steer words along real edges
    logic [LABEL_W-1:0]      lbl_shadow [MAX_STATES][MAX_STATES];
    logic [STATE_W-1:0]      walk_state;
    bit                      walk_dead;
    logic [NUM_STATES_W-1:0] num_shadow;
    logic [STATE_W-1:0]      init_shadow;

    int sent_items;
    int words;
    int settings;
    bit tx_quiet;
    bit rx_quiet;

    table_driven_moore_automaton_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    moore_run_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: stall a random number of cycles per item, sometimes only once it is waiting
    initial begin : result_sink
        int gap;
        forever begin
            gap = rx_quiet ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_ready <= 1'b0;
                if ($urandom_range(0, 1) == 1) begin
                    do @(posedge aclk); while (!m_valid);
                end
                repeat (gap) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic in_item_t make_item(input logic [2:0] k, input logic [3:0] f,
                                           input logic [3:0] t, input logic [7:0] sym,
                                           input logic [7:0] val);
        in_item_t it;
        it.kind = k;
        it.from_state = f;
        it.to_state = t;
        it.symbol = sym;
        it.state_value = val;
        return it;
    endfunction

    // unused fields carry noise
    function automatic in_item_t word_item(input logic [2:0] k, input logic [7:0] sym);
        return make_item(k, 4'($urandom), 4'($urandom), sym, 8'($urandom));
    endfunction

    task automatic push_item(input in_item_t it);
        int gap;
        int lim;
        bit hit;
        case (it.kind)
            KIND_LOAD_TRANS: begin
                lbl_shadow[it.from_state][it.to_state] = it.symbol;
                sent_items++;
            end
            KIND_LOAD_OUT: sent_items++;
            KIND_START: begin
                walk_state = init_shadow;
                walk_dead = 1'b0;
                words++;
                sent_items++;
            end
            KIND_SYMBOL: begin
                if (!walk_dead) begin
                    lim = (num_shadow > MAX_STATES) ? MAX_STATES : int'(num_shadow);
                    hit = 1'b0;
                    for (int j = 0; j < lim && !hit; j++) begin
                        if (it.symbol != '0 && lbl_shadow[walk_state][j] == it.symbol) begin
                            hit = 1'b1;
                            walk_state = STATE_W'(j);
                        end
                    end
                    walk_dead = !hit;
                    sent_items++;
                end
            end
            KIND_END: sent_items++;
            default: ;
        endcase
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // step the clock first so the checker has counted the item just accepted
    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_NUM_STATES: num_shadow = d[NUM_STATES_W-1:0];
            REG_INITIAL:    init_shadow = d[STATE_W-1:0];
            default: ;
        endcase
    endtask

    // upper bits of the state-count and initial-state writes carry garbage the block must drop
    task automatic configure(input logic [4:0] ns, input logic [3:0] init,
                             input logic [15:0] mask);
        go_idle();
        write_reg(REG_NUM_STATES, (16'($urandom) & 16'hFFE0) | 16'(ns));
        write_reg(REG_INITIAL, (16'($urandom) & 16'hFFF0) | 16'(init));
        write_reg(REG_FINAL_MASK, mask);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, 16'($urandom));
        settings++;
    endtask

    initial begin : stimulus
        int lim;
        int n;
        int r;
        int drain;
        logic [4:0] ns;
        logic [3:0] f;
        logic [3:0] t;
        logic [7:0] sym;
        logic [7:0] lbl;
        logic [7:0] cand [MAX_STATES];

        for (int a = 0; a < MAX_STATES; a++)
            for (int b = 0; b < MAX_STATES; b++)
                lbl_shadow[a][b] = '0;
        walk_state = '0;
        walk_dead = 1'b0;
        num_shadow = NUM_STATES_W'(MAX_STATES);
        init_shadow = '0;
        sent_items = 0;
        words = 0;
        settings = 0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every output entry is written before any word touches it
        for (int s = 0; s < MAX_STATES; s++)
            push_item(make_item(KIND_LOAD_OUT, 4'(s), 4'($urandom), 8'($urandom),
                                s == 0 ? 8'h00 : (s == 15 ? 8'hFF : 8'($urandom))));

        push_item(make_item(KIND_LOAD_TRANS, 4'd0, 4'd1, 8'hFF, 8'($urandom)));
        push_item(make_item(KIND_LOAD_TRANS, 4'd0, 4'd3, 8'hFF, 8'($urandom)));
        push_item(make_item(KIND_LOAD_TRANS, 4'd1, 4'd15, 8'h80, 8'($urandom)));
        push_item(make_item(KIND_LOAD_TRANS, 4'd15, 4'd0, 8'hAA, 8'($urandom)));
        push_item(make_item(KIND_LOAD_TRANS, 4'd0, 4'd15, 8'h01, 8'($urandom)));
        // end with no start yet: reports the reset state
        push_item(word_item(KIND_END, 8'($urandom)));
        push_item(word_item(KIND_START, 8'($urandom)));
        push_item(word_item(KIND_SYMBOL, 8'hFF));
        push_item(word_item(KIND_SYMBOL, 8'h80));
        push_item(word_item(KIND_SYMBOL, 8'hAA));
        push_item(word_item(KIND_SYMBOL, 8'h01));
        push_item(word_item(KIND_END, 8'($urandom)));
        // symbol zero kills the word; later symbols vanish, end repeats
        push_item(word_item(KIND_START, 8'($urandom)));
        push_item(word_item(KIND_SYMBOL, 8'h00));
        push_item(word_item(KIND_SYMBOL, 8'hFF));
        push_item(word_item(KIND_END, 8'($urandom)));
        push_item(word_item(KIND_END, 8'($urandom)));
        push_item(word_item(KIND_SPARE_LO, 8'($urandom)));
        push_item(word_item(KIND_SPARE_HI, 8'($urandom)));

        // empty scan
        configure(5'd0, 4'd0, 16'hFFFF);
        push_item(word_item(KIND_START, 8'($urandom)));
        push_item(word_item(KIND_SYMBOL, 8'hFF));
        push_item(word_item(KIND_END, 8'($urandom)));
        // oversized state count saturates, last state accepts
        configure(5'd31, 4'd15, 16'h8000);
        push_item(word_item(KIND_START, 8'($urandom)));
        push_item(word_item(KIND_SYMBOL, 8'hAA));
        push_item(word_item(KIND_SYMBOL, 8'h01));
        push_item(word_item(KIND_END, 8'($urandom)));
        // edge to state 15 lies beyond a two-state scan
        configure(5'd2, 4'd0, 16'h0003);
        push_item(word_item(KIND_START, 8'($urandom)));
        push_item(word_item(KIND_SYMBOL, 8'h01));
        push_item(word_item(KIND_END, 8'($urandom)));

        while (sent_items < ITEM_TARGET) begin
            tx_quiet = ($urandom_range(0, 5) == 0);
            rx_quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 2) == 0) begin
                r = $urandom_range(0, 9);
                case (r)
                    0: ns = 5'd0;
                    1: ns = 5'($urandom_range(17, 31));
                    2: ns = 5'd16;
                    3: ns = 5'd1;
                    default: ns = 5'($urandom_range(2, 16));
                endcase
                r = $urandom_range(0, 5);
                configure(ns, 4'($urandom),
                          r == 0 ? 16'h0000 : (r == 1 ? 16'hFFFF : 16'($urandom)));
            end
            lim = (num_shadow > MAX_STATES) ? MAX_STATES : int'(num_shadow);

            repeat ($urandom_range(2, 20)) begin
                f = 4'($urandom);
                if (lim > 0 && $urandom_range(0, 4) != 0)
                    t = 4'($urandom_range(0, lim - 1));
                else
                    t = 4'($urandom);
                r = $urandom_range(0, 19);
                if (r < 14)
                    lbl = 8'($urandom_range(1, 6));
                else if (r < 17)
                    lbl = 8'h00;
                else
                    lbl = 8'($urandom);
                push_item(make_item(KIND_LOAD_TRANS, f, t, lbl, 8'($urandom)));
            end
            repeat ($urandom_range(0, 2))
                push_item(make_item(KIND_LOAD_OUT, 4'($urandom), 4'($urandom),
                                    8'($urandom), 8'($urandom)));

            repeat ($urandom_range(1, 6)) begin
                push_item(word_item(KIND_START, 8'($urandom)));
                repeat ($urandom_range(0, 12)) begin
                    n = 0;
                    for (int j = 0; j < lim; j++) begin
                        if (lbl_shadow[walk_state][j] != '0) begin
                            cand[n] = lbl_shadow[walk_state][j];
                            n++;
                        end
                    end
                    r = $urandom_range(0, 19);
                    if (r < 16 && n > 0)
                        sym = cand[$urandom_range(0, n - 1)];
                    else if (r == 19)
                        sym = 8'h00;
                    else
                        sym = 8'($urandom);
                    push_item(word_item(KIND_SYMBOL, sym));
                    if ($urandom_range(0, 29) == 0)
                        push_item(word_item(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                                            8'($urandom)));
                end
                push_item(word_item(KIND_END, 8'($urandom)));
                if ($urandom_range(0, 4) == 0)
                    push_item(word_item(KIND_END, 8'($urandom)));
            end

            // stray items outside a well-formed word
            if ($urandom_range(0, 3) == 0)
                push_item(word_item(3'($urandom), 8'($urandom)));
            if ($urandom_range(0, 7) == 0)
                go_idle();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        $display("covered %0d items in %0d words over %0d register settings",
                 sent_items, words, settings);
        $display("%0d results compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/tdma_pkg.sv
hw/rtl/tdma_ram.sv
hw/rtl/table_driven_moore_automaton_unit.sv
hw/rtl/tdma_checker.sv
test/moore_run_checker.sv
test/tb_table_driven_moore_automaton_unit.sv
